// ----- rtl/tbpol_pkg.sv -----
`default_nettype none

package tbpol_pkg;

   localparam int FUNC_W     = 2;
   localparam int SRC_W      = 32;
   localparam int TIME_W     = 48;
   localparam int RATE_W     = 20;
   localparam int TOKEN_W    = 16;
   localparam int VIOL_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int TABLE_ENTRIES_DEF = 256;

   // stages in the refill arithmetic, table read to update
   localparam int REFILL_LAT = 5;

   localparam logic [FUNC_W-1:0] FUNC_ADMIT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UNBLOCK  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 2'd2;

   localparam logic [RATE_W-1:0]  RATE_RESET   = 20'd100;
   localparam logic [TOKEN_W-1:0] BURST_RESET  = 16'd20;
   localparam logic [VIOL_W-1:0]  THRESH_RESET = 8'd10;

   typedef struct packed {
      logic               valid;
      logic [SRC_W-1:0]   source;
      logic [TOKEN_W-1:0] tokens;
      logic [VIOL_W-1:0]  violations;
      logic               blocked;
      logic [TIME_W-1:0]  last_refill;
   } entry_type;

endpackage

`default_nettype wire

// ----- rtl/tbpol_ram.sv -----
`default_nettype none

module tbpol_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/tbpol_index.sv -----
`default_nettype none

// source_addr mod TABLE_ENTRIES in two stages: reciprocal estimate, then
// one back-multiply and a single correction step
module tbpol_index #(
   parameter int TABLE_ENTRIES = tbpol_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 advance,
   input  wire logic [tbpol_pkg::SRC_W-1:0]          src,
   output logic      [$clog2(TABLE_ENTRIES)-1:0]     idx
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int SRC_W   = tbpol_pkg::SRC_W;
   localparam int SHIFT   = SRC_W + IDX_W;
   localparam logic [63:0] RECIP_64 = (64'd1 << SHIFT) / 64'(TABLE_ENTRIES);
   localparam int RECIP_W = SRC_W + 1;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP_64);
   localparam int PROD_W  = SRC_W + RECIP_W;
   localparam logic [SRC_W-1:0] DEPTH_C = SRC_W'(TABLE_ENTRIES);

   logic [SRC_W-1:0]  src_a_ff;
   logic [PROD_W-1:0] prod_a_ff;
   logic [PROD_W-1:0] prod_a_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in;
   logic [SRC_W-1:0]  q_est;
   logic [SRC_W-1:0]  rem;
   logic [SRC_W-1:0]  rem_fix;

   // estimate is the true quotient or one below it
   assign prod_a_in = PROD_W'(src) * PROD_W'(RECIP_C);
   assign q_est     = SRC_W'(prod_a_ff >> SHIFT);
   assign rem       = src_a_ff - SRC_W'(q_est * DEPTH_C);
   assign rem_fix   = (rem >= DEPTH_C) ? rem - DEPTH_C : rem;
   assign idx_in    = rem_fix[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         src_a_ff  <= src;
         prod_a_ff <= prod_a_in;
         idx_ff    <= idx_in;
      end
   end

   assign idx = idx_ff;

endmodule

`default_nettype wire

// ----- rtl/tbpol_refill.sv -----
`default_nettype none

// floor(elapsed_us * rate / 1e6), saturated to the token width
module tbpol_refill (
   input  wire logic                              clock,
   input  wire logic [tbpol_pkg::TIME_W-1:0]      now,
   input  wire logic [tbpol_pkg::TIME_W-1:0]      last,
   input  wire logic [tbpol_pkg::RATE_W-1:0]      rate,
   output logic      [tbpol_pkg::TOKEN_W-1:0]     add
);

   localparam int TIME_W  = tbpol_pkg::TIME_W;
   localparam int RATE_W  = tbpol_pkg::RATE_W;
   localparam int TOKEN_W = tbpol_pkg::TOKEN_W;
   // 2^37 us fills any bucket at rate >= 1, so elapsed clamps there
   localparam int E_W     = 37;
   localparam int LO_W    = 20;
   localparam int HI_W    = E_W - LO_W;
   localparam int PH_W    = HI_W + RATE_W;
   localparam int PL_W    = LO_W + RATE_W;
   localparam int P_W     = E_W + RATE_W;
   // at or above this product the bucket gets a full token word
   localparam logic [P_W-1:0] P_SAT = P_W'(64'd65535000000);
   // 1e6 = 64 * 15625
   localparam int X_SHIFT = 6;
   localparam int X_W     = 30;
   localparam int DIV_W   = 15;
   localparam logic [DIV_W-1:0] DIV_C = 15'd15625;
   localparam int RCP_W   = 19;
   localparam int RCP_SH  = 32;
   localparam logic [RCP_W-1:0] RECIP_C = 19'd274877; // floor(2^32 / 15625)
   localparam int T_W     = X_W + RCP_W;

   logic [TIME_W-1:0]  elapsed;
   logic [E_W-1:0]     e_ff;
   logic [E_W-1:0]     e_in;
   logic [PH_W-1:0]    ph_ff;
   logic [PH_W-1:0]    ph_in;
   logic [PL_W-1:0]    pl_ff;
   logic [PL_W-1:0]    pl_in;
   logic [P_W-1:0]     p_sum;
   logic [X_W-1:0]     x3_ff;
   logic [X_W-1:0]     x3_in;
   logic               sat3_ff;
   logic               sat3_in;
   logic [T_W-1:0]     t_prod;
   logic [TOKEN_W-1:0] q4_ff;
   logic [TOKEN_W-1:0] q4_in;
   logic [X_W-1:0]     x4_ff;
   logic               sat4_ff;
   logic [X_W-1:0]     rem;
   logic [TOKEN_W-1:0] add_ff;
   logic [TOKEN_W-1:0] add_in;

   // time going backwards counts as no time
   assign elapsed = (now >= last) ? now - last : '0;
   assign e_in    = (|elapsed[TIME_W-1:E_W]) ? '1 : elapsed[E_W-1:0];

   assign ph_in = PH_W'(e_ff[E_W-1:LO_W]) * PH_W'(rate);
   assign pl_in = PL_W'(e_ff[LO_W-1:0]) * PL_W'(rate);

   assign p_sum   = (P_W'(ph_ff) << LO_W) + P_W'(pl_ff);
   assign sat3_in = (p_sum >= P_SAT);
   assign x3_in   = p_sum[X_SHIFT +: X_W];

   // quotient estimate, at most one short
   assign t_prod = T_W'(x3_ff) * T_W'(RECIP_C);
   assign q4_in  = t_prod[RCP_SH +: TOKEN_W];

   assign rem    = x4_ff - X_W'(X_W'(q4_ff) * X_W'(DIV_C));
   assign add_in = sat4_ff ? '1 : q4_ff + TOKEN_W'(rem >= X_W'(DIV_C));

   always_ff @(posedge clock) begin
      e_ff    <= e_in;
      ph_ff   <= ph_in;
      pl_ff   <= pl_in;
      x3_ff   <= x3_in;
      sat3_ff <= sat3_in;
      q4_ff   <= q4_in;
      x4_ff   <= x3_ff;
      sat4_ff <= sat3_ff;
      add_ff  <= add_in;
   end

   assign add = add_ff;

endmodule

`default_nettype wire

// ----- rtl/per_source_token_bucket_policer_core.sv -----
`default_nettype none

// Per-source token bucket policer.
// Requests: start/busy. A request is taken on a clock edge with start high
// and busy low; req_func selects admission, query or unblock for
// req_source_addr at time req_now_us.
// Results: one per request, in request order, shown for one cycle with
// rsp_strobe high. The receiver cannot hold results off.
// Config: csr_valid/csr_ready write of rate, burst size and block threshold
// by csr_index; csr_ready is always high. Write only while no request is in
// flight.
// Path: an accepted request passes index calculation, table read, five refill
// arithmetic stages, update and result register, in that order, before
// rsp_strobe rises; a stall holds it back in the front pipeline.
// Throughput: one request per cycle while no request maps to the same table
// entry as one of the six requests before it. A request whose entry is still
// being updated waits for the table write, and busy stays high meanwhile.
// Reset: clears the pipeline and then sweeps the bucket table, one entry per
// cycle, through all TABLE_ENTRIES entries; busy is high during the sweep.
module per_source_token_bucket_policer_core #(
   parameter int TABLE_ENTRIES = tbpol_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [tbpol_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [tbpol_pkg::SRC_W-1:0]           req_source_addr,
   input  wire logic [tbpol_pkg::TIME_W-1:0]          req_now_us,
   output logic                                       rsp_strobe,
   output logic                                       rsp_allowed,
   output logic                                       rsp_is_blocked,
   output logic                                       rsp_newly_blocked,
   output logic      [tbpol_pkg::TOKEN_W-1:0]         rsp_tokens_left,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [tbpol_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tbpol_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int LAT     = tbpol_pkg::REFILL_LAT;
   localparam int ENT_W   = $bits(tbpol_pkg::entry_type);
   localparam int TOKEN_W = tbpol_pkg::TOKEN_W;
   localparam int VIOL_W  = tbpol_pkg::VIOL_W;

   typedef struct packed {
      logic [tbpol_pkg::FUNC_W-1:0] func;
      logic [tbpol_pkg::SRC_W-1:0]  src;
      logic [tbpol_pkg::TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      req_type              req;
      logic [IDX_W-1:0]     idx;
      logic                 hit;
      tbpol_pkg::entry_type ent;
   } work_type;

   // configuration
   logic [tbpol_pkg::RATE_W-1:0] rate_ff;
   logic [TOKEN_W-1:0]           burst_ff;
   logic [VIOL_W-1:0]            thresh_ff;

   // table clear sweep
   logic             clr_active_ff;
   logic [IDX_W-1:0] clr_cnt_ff;

   // front pipeline
   logic       accept;
   logic       advance;
   logic       stall;
   logic       hazard;
   req_type    req_in;
   req_type    f0_ff;
   req_type    f1_ff;
   req_type    p0_ff;
   req_type    p1_ff;
   logic       f0_v_ff;
   logic       f1_v_ff;
   logic       p0_v_ff;
   logic       p1_v_ff;
   logic [IDX_W-1:0] p0_idx;
   logic [IDX_W-1:0] p1_idx_ff;

   // table
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ENT_W-1:0]     ram_wr_data;
   logic [ENT_W-1:0]     ram_rd_data;
   tbpol_pkg::entry_type rd_ent;
   tbpol_pkg::entry_type eff_ent;
   logic                 p1_hit;

   // refill stages
   work_type           c_in;
   work_type           c_ff [1:LAT];
   logic [LAT:1]       c_v_ff;
   logic [TOKEN_W-1:0] refill_add;

   // update
   work_type             w;
   tbpol_pkg::entry_type upd;
   logic [TOKEN_W:0]     tok_sum;
   logic                 wr_req;
   logic                 allowed_in;
   logic                 blocked_in;
   logic                 newly_in;
   logic [TOKEN_W-1:0]   tokens_in;

   logic               strobe_ff;
   logic               allowed_ff;
   logic               blocked_ff;
   logic               newly_ff;
   logic [TOKEN_W-1:0] tokens_ff;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= tbpol_pkg::RATE_RESET;
         burst_ff  <= tbpol_pkg::BURST_RESET;
         thresh_ff <= tbpol_pkg::THRESH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tbpol_pkg::CSR_RATE:   rate_ff   <= csr_data;
            tbpol_pkg::CSR_BURST:  burst_ff  <= csr_data[TOKEN_W-1:0];
            tbpol_pkg::CSR_THRESH: thresh_ff <= csr_data[VIOL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- clear sweep ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         if (clr_cnt_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // ---------------- front pipeline ----------------
   // an entry still on its way to the table write blocks a new read of it
   always_comb begin
      hazard = p1_v_ff && (p1_idx_ff == p0_idx);
      for (int i = 1; i <= LAT; i++) begin
         hazard = hazard | (c_v_ff[i] && (c_ff[i].idx == p0_idx));
      end
   end

   assign stall   = p0_v_ff && hazard;
   assign advance = !stall;
   assign busy    = clr_active_ff || stall;
   assign accept  = start && !busy;

   assign req_in.func = req_func;
   assign req_in.src  = req_source_addr;
   assign req_in.now  = req_now_us;

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_v_ff <= 1'b0;
         f1_v_ff <= 1'b0;
         p0_v_ff <= 1'b0;
         p1_v_ff <= 1'b0;
      end else begin
         if (advance) begin
            f0_v_ff <= accept;
            f1_v_ff <= f0_v_ff;
            p0_v_ff <= f1_v_ff;
         end
         p1_v_ff <= p0_v_ff && advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f0_ff     <= req_in;
         f1_ff     <= f0_ff;
         p0_ff     <= f1_ff;
         p1_ff     <= p0_ff;
         p1_idx_ff <= p0_idx;
      end
   end

   tbpol_index #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_index (
      .clock  (clock),
      .advance(advance),
      .src    (f0_ff.src),
      .idx    (p0_idx)
   );

   // ---------------- table ----------------
   tbpol_ram #(
      .WIDTH(ENT_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(p0_idx),
      .rd_data(ram_rd_data)
   );

   assign rd_ent = tbpol_pkg::entry_type'(ram_rd_data);
   assign p1_hit = rd_ent.valid && (rd_ent.source == p1_ff.src);

   // admission of an absent source starts from a fresh, full bucket
   always_comb begin
      eff_ent = rd_ent;
      if (p1_ff.func == tbpol_pkg::FUNC_ADMIT && !p1_hit) begin
         eff_ent.valid       = 1'b1;
         eff_ent.source      = p1_ff.src;
         eff_ent.tokens      = burst_ff;
         eff_ent.violations  = '0;
         eff_ent.blocked     = 1'b0;
         eff_ent.last_refill = p1_ff.now;
      end
      c_in.req = p1_ff;
      c_in.idx = p1_idx_ff;
      c_in.hit = p1_hit;
      c_in.ent = eff_ent;
   end

   // ---------------- refill stages ----------------
   tbpol_refill u_refill (
      .clock(clock),
      .now  (p1_ff.now),
      .last (eff_ent.last_refill),
      .rate (rate_ff),
      .add  (refill_add)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= '0;
      end else begin
         c_v_ff <= {c_v_ff[LAT-1:1], p1_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      c_ff[1] <= c_in;
      for (int i = 2; i <= LAT; i++) begin
         c_ff[i] <= c_ff[i-1];
      end
   end

   // ---------------- bucket update ----------------
   assign w = c_ff[LAT];

   always_comb begin
      upd        = w.ent;
      tok_sum    = '0;
      wr_req     = 1'b0;
      allowed_in = 1'b0;
      blocked_in = 1'b0;
      newly_in   = 1'b0;
      tokens_in  = '0;
      case (w.req.func) inside
         tbpol_pkg::FUNC_ADMIT: begin
            wr_req = 1'b1;
            if (!upd.blocked) begin
               // refill time moves only when a token is earned
               if (refill_add != '0) begin
                  tok_sum = {1'b0, upd.tokens} + {1'b0, refill_add};
                  if (tok_sum > {1'b0, burst_ff}) begin
                     upd.tokens = burst_ff;
                  end else begin
                     upd.tokens = tok_sum[TOKEN_W-1:0];
                  end
                  upd.last_refill = w.req.now;
               end
               if (upd.tokens != '0) begin
                  upd.tokens = upd.tokens - TOKEN_W'(1);
                  allowed_in = 1'b1;
               end else begin
                  if (upd.violations != '1) begin
                     upd.violations = upd.violations + VIOL_W'(1);
                  end
                  if (upd.violations >= thresh_ff) begin
                     upd.blocked = 1'b1;
                     newly_in    = 1'b1;
                  end
               end
            end
            blocked_in = upd.blocked;
            tokens_in  = upd.tokens;
         end
         tbpol_pkg::FUNC_UNBLOCK: begin
            if (w.hit) begin
               wr_req         = 1'b1;
               upd.blocked    = 1'b0;
               upd.violations = '0;
               upd.tokens     = burst_ff;
               tokens_in      = burst_ff;
            end
         end
         tbpol_pkg::FUNC_QUERY, tbpol_pkg::FUNC_RESERVED: begin
            if (w.hit) begin
               blocked_in = upd.blocked;
               tokens_in  = upd.tokens;
            end
         end
         default: ;
      endcase
   end

   assign ram_wr_en   = clr_active_ff || (c_v_ff[LAT] && wr_req);
   assign ram_wr_addr = clr_active_ff ? clr_cnt_ff : w.idx;
   assign ram_wr_data = clr_active_ff ? '0 : ENT_W'(upd);

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= c_v_ff[LAT];
      end
   end

   always_ff @(posedge clock) begin
      allowed_ff <= allowed_in;
      blocked_ff <= blocked_in;
      newly_ff   <= newly_in;
      tokens_ff  <= tokens_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_allowed       = allowed_ff;
   assign rsp_is_blocked    = blocked_ff;
   assign rsp_newly_blocked = newly_ff;
   assign rsp_tokens_left   = tokens_ff;

endmodule

`default_nettype wire

// ----- rtl/tbpol_checker.sv -----
`default_nettype none

module tbpol_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire logic rsp_allowed,
   input wire logic rsp_is_blocked,
   input wire logic rsp_newly_blocked
);

   // table sweep follows every reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // a request that blocks its source was refused
   a_newly_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_newly_blocked) |-> (rsp_is_blocked && !rsp_allowed))
      else $error("newly blocked result inconsistent");

   a_allowed_unblocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_allowed) |-> !rsp_is_blocked)
      else $error("admitted request reports blocked source");

endmodule

bind per_source_token_bucket_policer_core tbpol_checker u_tbpol_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_allowed      (rsp_allowed),
   .rsp_is_blocked   (rsp_is_blocked),
   .rsp_newly_blocked(rsp_newly_blocked)
);

`default_nettype wire

// ----- bench/tbpol_checker.sv -----
module tbpol_bench_checker
   import tbpol_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [SRC_W-1:0]      req_source_addr,
   input  wire logic [TIME_W-1:0]     req_now_us,
   input  wire logic                  rsp_strobe,
   input  wire logic                  rsp_allowed,
   input  wire logic                  rsp_is_blocked,
   input  wire logic                  rsp_newly_blocked,
   input  wire logic [TOKEN_W-1:0]    rsp_tokens_left,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output int                         mismatch_count,
   output int                         outstanding,
   output int                         rsp_total,
   output int                         allowed_total,
   output int                         block_total
);

   localparam logic [63:0] US_PER_SEC = 64'd1000000;

   typedef struct packed {
      logic               allowed;
      logic               is_blocked;
      logic               newly_blocked;
      logic [TOKEN_W-1:0] tokens_left;
   } verdict_type;

   verdict_type expected_verdicts [$];

   logic               bkt_valid     [TABLE_ENTRIES];
   logic [SRC_W-1:0]   bkt_source    [TABLE_ENTRIES];
   logic [TOKEN_W-1:0] bkt_tokens    [TABLE_ENTRIES];
   logic [VIOL_W-1:0]  bkt_viol      [TABLE_ENTRIES];
   logic               bkt_blocked   [TABLE_ENTRIES];
   logic [TIME_W-1:0]  bkt_refill_us [TABLE_ENTRIES];

   logic [RATE_W-1:0]  rate_cfg;
   logic [TOKEN_W-1:0] burst_cfg;
   logic [VIOL_W-1:0]  thresh_cfg;

   // whole seconds and the sub-second remainder are scaled apart so the
   // floor matches an exact elapsed*rate/1e6
   function automatic logic [63:0] earned_tokens(input logic [TIME_W-1:0] elapsed);
      logic [63:0] whole_sec;
      logic [63:0] frac_us;
      whole_sec = elapsed / US_PER_SEC;
      frac_us   = elapsed % US_PER_SEC;
      return whole_sec * rate_cfg + (frac_us * rate_cfg) / US_PER_SEC;
   endfunction

   function automatic verdict_type police_request(input logic [FUNC_W-1:0] fn,
                                                  input logic [SRC_W-1:0]  src,
                                                  input logic [TIME_W-1:0] now);
      verdict_type       v;
      int unsigned       slot;
      logic              hit;
      logic [TIME_W-1:0] elapsed;
      logic [63:0]       earned;
      logic [63:0]       level;
      v    = '0;
      slot = src % TABLE_ENTRIES;
      hit  = bkt_valid[slot] && (bkt_source[slot] == src);
      case (fn)
         FUNC_ADMIT: begin
            if (!hit) begin
               // new source, or eviction of whatever held this slot
               bkt_valid[slot]     = 1'b1;
               bkt_source[slot]    = src;
               bkt_tokens[slot]    = burst_cfg;
               bkt_viol[slot]      = '0;
               bkt_blocked[slot]   = 1'b0;
               bkt_refill_us[slot] = now;
            end
            if (!bkt_blocked[slot]) begin
               elapsed = (now >= bkt_refill_us[slot]) ?
                         now - bkt_refill_us[slot] : '0;
               earned  = earned_tokens(elapsed);
               if (earned != 0) begin
                  level = bkt_tokens[slot] + earned;
                  if (level > burst_cfg) level = burst_cfg;
                  bkt_tokens[slot]    = level[TOKEN_W-1:0];
                  bkt_refill_us[slot] = now;
               end
               if (bkt_tokens[slot] != 0) begin
                  bkt_tokens[slot] = bkt_tokens[slot] - TOKEN_W'(1);
                  v.allowed = 1'b1;
               end else begin
                  if (bkt_viol[slot] != '1) bkt_viol[slot] = bkt_viol[slot] + VIOL_W'(1);
                  if (bkt_viol[slot] >= thresh_cfg) begin
                     bkt_blocked[slot] = 1'b1;
                     v.newly_blocked = 1'b1;
                  end
               end
            end
            v.is_blocked  = bkt_blocked[slot];
            v.tokens_left = bkt_tokens[slot];
         end
         FUNC_UNBLOCK: begin
            if (hit) begin
               bkt_blocked[slot] = 1'b0;
               bkt_viol[slot]    = '0;
               bkt_tokens[slot]  = burst_cfg;
               v.tokens_left     = burst_cfg;
            end
         end
         default: begin
            // query; the reserved code behaves the same
            if (hit) begin
               v.is_blocked  = bkt_blocked[slot];
               v.tokens_left = bkt_tokens[slot];
            end
         end
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type seen;
      verdict_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            bkt_valid[i]     = 1'b0;
            bkt_source[i]    = '0;
            bkt_tokens[i]    = '0;
            bkt_viol[i]      = '0;
            bkt_blocked[i]   = 1'b0;
            bkt_refill_us[i] = '0;
         end
         rate_cfg   = RATE_RESET;
         burst_cfg  = BURST_RESET;
         thresh_cfg = THRESH_RESET;
         expected_verdicts.delete();
         mismatch_count = 0;
         rsp_total      = 0;
         allowed_total  = 0;
         block_total    = 0;
         outstanding   <= 0;
      end else begin
         if (rsp_strobe) begin
            seen = '{rsp_allowed, rsp_is_blocked, rsp_newly_blocked, rsp_tokens_left};
            rsp_total++;
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result allowed=%0b blocked=%0b %s%0b tokens=%0d",
                           $time, seen.allowed, seen.is_blocked, "newly=",
                           seen.newly_blocked, seen.tokens_left);
            end else begin
               want = expected_verdicts.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: result mismatch: expected allowed=%0b blocked=%0b %s%0b %s%0d",
                              $time, want.allowed, want.is_blocked, "newly=",
                              want.newly_blocked, "tokens=", want.tokens_left);
                     $display("%0t:                  got allowed=%0b blocked=%0b %s%0b %s%0d",
                              $time, seen.allowed, seen.is_blocked, "newly=",
                              seen.newly_blocked, "tokens=", seen.tokens_left);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RATE:   rate_cfg   = csr_data[RATE_W-1:0];
               CSR_BURST:  burst_cfg  = csr_data[TOKEN_W-1:0];
               CSR_THRESH: thresh_cfg = csr_data[VIOL_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            want = police_request(req_func, req_source_addr, req_now_us);
            if (want.allowed) allowed_total++;
            if (want.newly_blocked) block_total++;
            expected_verdicts.push_back(want);
         end
         outstanding <= expected_verdicts.size();
      end
   end

endmodule

// ----- bench/tb_per_source_token_bucket_policer_core.sv -----
module tb_per_source_token_bucket_policer_core;
   import tbpol_pkg::*;

   localparam int STALL_LIMIT       = 5000;
   localparam int ITEMS_PER_SETTING = 150;
   localparam int POOL_SIZE         = 12;
   localparam int HOT_SLOTS         = 6;
   localparam int SETTLE_CYCLES     = 12;

   // outside the register map; the block must drop these writes
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [SRC_W-1:0]      req_source_addr = '0;
   logic [TIME_W-1:0]     req_now_us = '0;
   logic                  rsp_strobe;
   logic                  rsp_allowed;
   logic                  rsp_is_blocked;
   logic                  rsp_newly_blocked;
   logic [TOKEN_W-1:0]    rsp_tokens_left;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int mismatch_count;
   int outstanding;
   int rsp_total;
   int allowed_total;
   int block_total;

   int                idle_pct = 0;
   int                requests_sent = 0;
   int                settings_used = 0;
   int                stall_cycles = 0;
   logic [TIME_W-1:0] wall_us = '0;
   logic [SRC_W-1:0]  source_pool [POOL_SIZE];
   logic [7:0]        hot_slot [HOT_SLOTS];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   per_source_token_bucket_policer_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_source_addr   (req_source_addr),
      .req_now_us        (req_now_us),
      .rsp_strobe        (rsp_strobe),
      .rsp_allowed       (rsp_allowed),
      .rsp_is_blocked    (rsp_is_blocked),
      .rsp_newly_blocked (rsp_newly_blocked),
      .rsp_tokens_left   (rsp_tokens_left),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   tbpol_bench_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_source_addr   (req_source_addr),
      .req_now_us        (req_now_us),
      .rsp_strobe        (rsp_strobe),
      .rsp_allowed       (rsp_allowed),
      .rsp_is_blocked    (rsp_is_blocked),
      .rsp_newly_blocked (rsp_newly_blocked),
      .rsp_tokens_left   (rsp_tokens_left),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding),
      .rsp_total         (rsp_total),
      .allowed_total     (allowed_total),
      .block_total       (block_total)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", stall_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [SRC_W-1:0] src,
                               input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_func        <= fn;
      req_source_addr <= src;
      req_now_us      <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      requests_sent++;
   endtask

   // unused data bits carry noise so masking in the register file is exercised
   task automatic program_settings(input logic [RATE_W-1:0] rate,
                                   input logic [TOKEN_W-1:0] depth,
                                   input logic [VIOL_W-1:0] thresh);
      logic [CSR_IDX_W-1:0]  idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      logic [31:0]           noise;
      noise  = $urandom();
      idx[0] = CSR_RATE;     val[0] = rate;
      idx[1] = CSR_BURST;    val[1] = {noise[3:0], depth};
      idx[2] = CSR_THRESH;   val[2] = {noise[15:4], thresh};
      idx[3] = CSR_UNMAPPED; val[3] = noise[31:12];
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic refresh_pool(input int from);
      logic [31:0] tag;
      for (int i = from; i < POOL_SIZE; i++) begin
         tag = $urandom();
         source_pool[i] = {tag[31:8], hot_slot[i % HOT_SLOTS]};
      end
   endtask

   // mostly a forward-running clock; rare backward steps and wild jumps
   function automatic logic [TIME_W-1:0] pick_time();
      logic [63:0] wide;
      int unsigned roll;
      roll = $urandom_range(99);
      wide = {$urandom(), $urandom()};
      if (roll < 1) return wide[TIME_W-1:0];
      if (roll < 3)
         return (wall_us > 5000) ? wall_us - TIME_W'($urandom_range(1, 5000)) : wall_us;
      if (roll < 60) wall_us += TIME_W'($urandom_range(0, 400));
      else if (roll < 88) wall_us += TIME_W'($urandom_range(0, 5000));
      else wall_us += TIME_W'($urandom_range(0, 3000000));
      return wall_us;
   endfunction

   // runs of requests at one source drain its bucket; the rest is noise
   task automatic run_traffic(input int count);
      int               sent;
      int               run_len;
      int unsigned      roll;
      logic [SRC_W-1:0] focus;
      logic [SRC_W-1:0] src;
      logic [FUNC_W-1:0] fn;
      sent = 0;
      while (sent < count) begin
         focus   = source_pool[$urandom_range(POOL_SIZE - 1)];
         run_len = $urandom_range(1, 10);
         for (int k = 0; k < run_len && sent < count; k++) begin
            roll = $urandom_range(99);
            src  = focus;
            fn   = FUNC_ADMIT;
            if (roll < 8) fn = FUNC_QUERY;
            else if (roll < 15) fn = FUNC_UNBLOCK;
            else if (roll < 17) fn = FUNC_RESERVED;
            else if (roll < 22) src = source_pool[$urandom_range(POOL_SIZE - 1)];
            else if (roll < 25) src = $urandom();
            send_request(fn, src, pick_time());
            sent++;
         end
      end
   endtask

   initial begin
      logic [SRC_W-1:0] src_a;
      logic [SRC_W-1:0] src_b;
      src_a = 32'h0000_0005;
      src_b = 32'h0000_0105;   // same slot as src_a

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);   // table sweep

      idle_pct = 37;
      // reset settings: absent source, then a fresh bucket
      send_request(FUNC_QUERY, 32'h0, 48'd0);
      send_request(FUNC_UNBLOCK, 32'h0, 48'd0);
      send_request(FUNC_ADMIT, 32'h0, 48'd0);
      quiesce();
      program_settings(20'd1000, 16'd2, 8'd2);
      send_request(FUNC_ADMIT, src_a, 48'd1000);
      send_request(FUNC_ADMIT, src_a, 48'd1000);
      send_request(FUNC_ADMIT, src_a, 48'd1999);   // just short of a token
      send_request(FUNC_ADMIT, src_a, 48'd2000);
      send_request(FUNC_ADMIT, src_a, 48'd2000);   // reaches threshold
      send_request(FUNC_ADMIT, src_a, 48'd9000);   // blocked, no change
      send_request(FUNC_QUERY, src_a, 48'd9000);
      send_request(FUNC_RESERVED, src_a, 48'd9000);
      send_request(FUNC_UNBLOCK, src_a, 48'd9000);
      send_request(FUNC_ADMIT, src_a, 48'd500);    // time went backwards
      send_request(FUNC_ADMIT, src_b, 48'd600);    // evicts src_a
      send_request(FUNC_QUERY, src_a, 48'd600);
      send_request(FUNC_UNBLOCK, src_a, 48'd600);
      send_request(FUNC_ADMIT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_request(FUNC_ADMIT, 32'hFFFF_FFFF, 48'd0);
      send_request(FUNC_ADMIT, 32'h0, 48'd5000);   // stored count above new burst
      quiesce();
      program_settings(20'd1000000, 16'd0, 8'd0);
      send_request(FUNC_ADMIT, 32'h1234_5600, 48'd10);   // first violation blocks
      send_request(FUNC_ADMIT, src_b, 48'h8000_0000_0000);
      send_request(FUNC_ADMIT, src_a, 48'h8000_0000_0001); // evicts a blocked source
      send_request(FUNC_QUERY, src_b, 48'h8000_0000_0001);

      for (int i = 0; i < HOT_SLOTS; i++) hot_slot[i] = 8'($urandom_range(255));
      refresh_pool(0);
      wall_us = 48'd100000 + TIME_W'($urandom_range(0, 1000000));

      for (int phase = 0; phase < 6; phase++) begin
         quiesce();
         if (phase > 0) refresh_pool(POOL_SIZE - 4);
         case (phase)
            0: begin
               idle_pct = 37;
               program_settings(20'd1000000, 16'd65535, 8'd255);
            end
            1: program_settings(20'd1000, 16'd4, 8'd3);
            2: begin
               idle_pct = 77;
               program_settings(20'd0, 16'd0, 8'd1);
            end
            3: program_settings(RATE_W'($urandom_range(1, 200000)),
                                TOKEN_W'($urandom_range(1, 6)),
                                VIOL_W'($urandom_range(1, 4)));
            4: begin
               idle_pct = 0;
               program_settings(20'd250, 16'd2, 8'd1);
            end
            default: program_settings(RATE_W'($urandom_range(0, 1000000)),
                                      TOKEN_W'($urandom_range(0, 12)),
                                      VIOL_W'($urandom_range(0, 8)));
         endcase
         run_traffic(ITEMS_PER_SETTING);
      end
      quiesce();

      $display("covered %0d requests over %0d policer settings and three pacing modes",
               requests_sent, settings_used);
      $display("%0d results checked: %0d admitted, %0d sources newly blocked",
               rsp_total, allowed_total, block_total);
      if (outstanding != 0) $display("%0d results never arrived", outstanding);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tbpol_pkg.sv
rtl/tbpol_ram.sv
rtl/tbpol_index.sv
rtl/tbpol_refill.sv
rtl/per_source_token_bucket_policer_core.sv
rtl/tbpol_checker.sv
bench/tbpol_checker.sv
bench/tb_per_source_token_bucket_policer_core.sv
